// ===== rtl/core/i2cms_pkg.sv =====
// ----------------------------------------------------------------------------
// i2cms_pkg
// Types, sizes and codes shared by the I2C master packet sequencer.
// ----------------------------------------------------------------------------
package i2cms_pkg;

  localparam int UQ_DEPTH = 64;   // user byte queue, bytes
  localparam int TR_DEPTH = 32;   // longest packet, bytes
  localparam int RX_DEPTH = 32;   // receive queue, bytes

  // user bytes live in one store addressed by free-running pointers; it is large
  // enough that a loaded packet is never overwritten while it is on the bus
  localparam int UM_AW    = $clog2(UQ_DEPTH + TR_DEPTH);
  localparam int UM_DEPTH = 1 << UM_AW;
  localparam int UC_W     = $clog2(UQ_DEPTH + 1);
  localparam int PL_AW    = $clog2(UQ_DEPTH);
  localparam int TL_W     = $clog2(TR_DEPTH + 1);
  localparam int RX_AW    = $clog2(RX_DEPTH);
  localparam int RX_CW    = $clog2(RX_DEPTH + 1);

  localparam logic [7:0] ST_START    = 8'h08;
  localparam logic [7:0] ST_RESTART  = 8'h10;
  localparam logic [7:0] ST_AW_ACK   = 8'h18;
  localparam logic [7:0] ST_DW_ACK   = 8'h28;
  localparam logic [7:0] ST_AR_ACK   = 8'h40;
  localparam logic [7:0] ST_DR_ACK   = 8'h50;
  localparam logic [7:0] ST_DR_NACK  = 8'h58;

  typedef enum logic [2:0] {
    CMD_HEADER = 3'd0,
    CMD_DATA   = 3'd1,
    CMD_KICK   = 3'd2,
    CMD_EVENT  = 3'd3,
    CMD_POP    = 3'd4
  } cmd_t;

  typedef enum logic [2:0] {
    ACT_NONE  = 3'd0,
    ACT_START = 3'd1,
    ACT_STOP  = 3'd2,
    ACT_ACK   = 3'd3,
    ACT_NACK  = 3'd4
  } act_t;

  typedef enum logic [1:0] {
    PH_UNSET   = 2'd0,
    PH_STANDBY = 2'd1,
    PH_WRITING = 2'd2,
    PH_READING = 2'd3
  } phase_t;

  typedef struct packed {
    act_t       act;
    logic [7:0] send_byte;
    logic [7:0] rx_byte;
    logic       rx_empty;
    logic       bus_error;
    phase_t     bus_state;
    logic [6:0] pending;
    logic       last;
  } res_t;

  // results of one word: one or two
  typedef struct packed {
    logic two;
    res_t r0;
    res_t r1;
  } res_pair_t;

endpackage

// ===== rtl/core/i2cms_if.sv =====
// ----------------------------------------------------------------------------
// i2cms_in_if / i2cms_out_if
// Valid/ready channels for host words and sequencer results.
// ----------------------------------------------------------------------------
interface i2cms_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] cmd;
  logic [6:0] slave_address;
  logic       read_mode;
  logic [7:0] data_byte;
  logic       last_of_packet;
  logic [7:0] bus_status;
  logic [7:0] bus_data;
  modport source (output valid, cmd, slave_address, read_mode, data_byte,
                  last_of_packet, bus_status, bus_data, input ready);
  modport sink   (input valid, cmd, slave_address, read_mode, data_byte,
                  last_of_packet, bus_status, bus_data, output ready);
endinterface

interface i2cms_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] bus_action;
  logic [7:0] send_byte;
  logic [7:0] rx_byte;
  logic       rx_empty;
  logic       bus_error;
  logic [1:0] bus_state;
  logic [6:0] pending_packets;
  logic       last_result;
  modport source (output valid, bus_action, send_byte, rx_byte, rx_empty, bus_error,
                  bus_state, pending_packets, last_result, input ready);
  modport sink   (input valid, bus_action, send_byte, rx_byte, rx_empty, bus_error,
                  bus_state, pending_packets, last_result, output ready);
endinterface

// ===== rtl/core/i2cms_ctrl.sv =====
// ----------------------------------------------------------------------------
// i2cms_ctrl
// Queue pointers, byte stores and bus reaction logic; one word per cycle while fire is high.
// ----------------------------------------------------------------------------
module i2cms_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  fire,
  input  logic [2:0]            cmd,
  input  logic [6:0]            slave_address,
  input  logic                  read_mode,
  input  logic [7:0]            data_byte,
  input  logic                  last_of_packet,
  input  logic [7:0]            bus_status,
  input  logic [7:0]            bus_data,
  output i2cms_pkg::res_pair_t  res
);
  import i2cms_pkg::*;

  logic [7:0]      um_mem [UM_DEPTH];
  logic [TL_W:0]   pl_mem [UQ_DEPTH];
  logic [7:0]      rx_mem [RX_DEPTH];

  logic [UM_AW-1:0] uhead_r, uhead_nxt, tbase_r, tbase_nxt;
  logic [UC_W-1:0]  ucnt_r, ucnt_nxt, ucnt_adj;
  logic [TL_W-1:0]  blen_r, blen_nxt, tlen_r, tlen_nxt, tidx_r, tidx_nxt, ld_len;
  logic             bldrd_r, bldrd_nxt, rcmem_r, rcmem_nxt;
  logic [PL_AW-1:0] phead_r, phead_nxt;
  logic [6:0]       pcnt_r, pcnt_nxt;
  logic [7:0]       hdr_r, hdr_nxt, rcnt_r, rcnt_nxt;
  logic [RX_AW-1:0] rhead_r, rhead_nxt;
  logic [RX_CW-1:0] rxcnt_r, rxcnt_nxt;
  phase_t           phase_r, phase_nxt;

  // prefetched read data for the current state
  logic [7:0]  a_q, b_q, rx_q;
  logic [TL_W:0] pl_q;

  logic             um_we, pl_we, rx_we;
  logic [UM_AW-1:0] um_wa, a_addr, b_addr;
  logic [7:0]       um_wd, rx_wd;
  logic [PL_AW-1:0] pl_wa, pl_addr;
  logic [TL_W:0]    pl_wd;
  logic [RX_AW-1:0] rx_wa, rx_addr;
  logic [TL_W-1:0]  a_idx;

  logic       do_load, do_close, close_rd, rx_push, stop, err;
  logic [TL_W-1:0] close_len;
  logic [7:0] rc_eff, rc_val, c_new;
  res_t       r0, r1;
  logic       two;

  always_comb begin
    uhead_nxt = uhead_r;  tbase_nxt = tbase_r;  ucnt_nxt = ucnt_r;
    blen_nxt  = blen_r;   tlen_nxt  = tlen_r;   tidx_nxt = tidx_r;
    bldrd_nxt = bldrd_r;  rcmem_nxt = rcmem_r;  phead_nxt = phead_r;
    pcnt_nxt  = pcnt_r;   hdr_nxt   = hdr_r;    rcnt_nxt = rcnt_r;
    rhead_nxt = rhead_r;  rxcnt_nxt = rxcnt_r;  phase_nxt = phase_r;
    um_we = 1'b0; um_wa = '0; um_wd = '0;
    pl_we = 1'b0; pl_wa = '0; pl_wd = '0;
    rx_we = 1'b0; rx_wa = '0; rx_wd = bus_data;
    do_load = 1'b0; do_close = 1'b0; close_rd = bldrd_r; close_len = blen_r;
    rx_push = 1'b0; stop = 1'b0; err = 1'b0; two = 1'b0;
    r0 = '0; r1 = '0;
    r0.act = ACT_NONE; r1.act = ACT_NONE;

    ld_len   = pl_q[TL_W-1:0];
    rc_eff   = rcmem_r ? a_q : rcnt_r;
    rc_val   = (tlen_r >= TL_W'(2)) ? rc_eff : 8'd0;
    c_new    = rc_val;
    ucnt_adj = ucnt_r - UC_W'(blen_r);

    unique case (cmd)
      CMD_HEADER: begin
        ucnt_nxt = ucnt_adj;
        blen_nxt = '0;
        if (ucnt_adj < UC_W'(UQ_DEPTH)) begin
          um_we     = 1'b1;
          um_wa     = uhead_r + UM_AW'(ucnt_adj);
          um_wd     = {slave_address, read_mode};
          ucnt_nxt  = ucnt_adj + UC_W'(1);
          blen_nxt  = TL_W'(1);
          bldrd_nxt = read_mode;
          close_rd  = read_mode;
          close_len = TL_W'(1);
          do_close  = last_of_packet;
        end
      end
      CMD_DATA: begin
        if (blen_r != '0) begin
          close_len = blen_r;
          if (ucnt_r < UC_W'(UQ_DEPTH) && blen_r < TL_W'(TR_DEPTH)) begin
            um_we     = 1'b1;
            um_wa     = uhead_r + UM_AW'(ucnt_r);
            um_wd     = data_byte;
            ucnt_nxt  = ucnt_r + UC_W'(1);
            blen_nxt  = blen_r + TL_W'(1);
            close_len = blen_r + TL_W'(1);
          end
          do_close = last_of_packet;
        end
      end
      CMD_KICK: begin
        if (phase_r != PH_WRITING && phase_r != PH_READING && pcnt_r != '0) begin
          do_load = 1'b1;
          r0.act  = ACT_START;
        end
      end
      CMD_EVENT: begin
        unique case (bus_status) inside
          ST_START, ST_RESTART: begin
            tidx_nxt     = TL_W'(1);
            r0.act       = ACT_ACK;
            r0.send_byte = hdr_r;
          end
          ST_AW_ACK, ST_DW_ACK: begin
            if (tidx_r < tlen_r) begin
              r0.act = ACT_ACK;
              if (tidx_r == '0) r0.send_byte = hdr_r;
              else if (tidx_r == TL_W'(1)) r0.send_byte = rc_eff;
              else r0.send_byte = a_q;
              // byte one leaves the prefetch window: keep it locally
              if (tidx_r == TL_W'(1) && rcmem_r) begin
                rcnt_nxt  = a_q;
                rcmem_nxt = 1'b0;
              end
              tidx_nxt = tidx_r + TL_W'(1);
            end else if (pcnt_r == '0 || !pl_q[TL_W]) begin
              stop = 1'b1;
            end else begin
              do_load = 1'b1;
              r0.act  = ACT_START;
            end
          end
          ST_AR_ACK: begin
            r0.act = (rc_val <= 8'd1) ? ACT_NACK : ACT_ACK;
          end
          ST_DR_ACK: begin
            rx_push = 1'b1;
            if (tlen_r >= TL_W'(2) && rc_val != 8'd0) begin
              c_new     = rc_val - 8'd1;
              rcnt_nxt  = c_new;
              rcmem_nxt = 1'b0;
            end
            r0.act = (c_new <= 8'd1) ? ACT_NACK : ACT_ACK;
          end
          ST_DR_NACK: begin
            rx_push = 1'b1;
            stop    = 1'b1;
          end
          default: begin
            stop = 1'b1;
            err  = 1'b1;
          end
        endcase
      end
      CMD_POP: begin
        if (rxcnt_r != '0) begin
          r0.rx_byte = rx_q;
          rhead_nxt  = rhead_r + RX_AW'(1);
          rxcnt_nxt  = rxcnt_r - RX_CW'(1);
        end else begin
          r0.rx_byte  = 8'hFF;
          r0.rx_empty = 1'b1;
        end
      end
      default: ;
    endcase

    if (do_close) begin
      if (pcnt_r < 7'(UQ_DEPTH)) begin
        pl_we    = 1'b1;
        pl_wa    = phead_r + PL_AW'(pcnt_r);
        pl_wd    = {close_rd, close_len};
        pcnt_nxt = pcnt_r + 7'd1;
      end
      blen_nxt = '0;
    end

    if (rx_push && rxcnt_r < RX_CW'(RX_DEPTH)) begin
      rx_we     = 1'b1;
      rx_wa     = rhead_r + RX_AW'(rxcnt_r);
      rxcnt_nxt = rxcnt_r + RX_CW'(1);
    end

    if (stop) begin
      phase_nxt = PH_STANDBY;
      tlen_nxt  = '0;
      r0.act    = ACT_STOP;
      if (pcnt_r != '0) begin
        do_load = 1'b1;
        two     = 1'b1;
        r1.act  = ACT_START;
      end
    end

    if (do_load) begin
      phead_nxt = phead_r + PL_AW'(1);
      pcnt_nxt  = pcnt_r - 7'd1;
      tbase_nxt = uhead_r;
      uhead_nxt = uhead_r + UM_AW'(ld_len);
      ucnt_nxt  = ucnt_r - UC_W'(ld_len);
      tlen_nxt  = ld_len;
      tidx_nxt  = '0;
      hdr_nxt   = b_q;
      rcmem_nxt = 1'b1;
      phase_nxt = b_q[0] ? PH_READING : PH_WRITING;
    end

    r0.bus_error = err;
    r1.bus_error = err;
    if (two) begin
      r0.bus_state = PH_STANDBY;
      r0.pending   = pcnt_r;
      r0.last      = 1'b0;
    end else begin
      r0.bus_state = phase_nxt;
      r0.pending   = pcnt_nxt;
      r0.last      = 1'b1;
    end
    r1.bus_state = phase_nxt;
    r1.pending   = pcnt_nxt;
    r1.last      = 1'b1;
  end

  assign res = '{two: two, r0: r0, r1: r1};

  // read addresses follow the state the next word will see
  always_comb begin
    a_idx   = fire ? tidx_nxt : tidx_r;
    if (a_idx == '0) a_idx = TL_W'(1);
    a_addr  = (fire ? tbase_nxt : tbase_r) + UM_AW'(a_idx);
    b_addr  = fire ? uhead_nxt : uhead_r;
    pl_addr = fire ? phead_nxt : phead_r;
    rx_addr = fire ? rhead_nxt : rhead_r;
  end

  always_ff @(posedge clk) begin
    if (fire && um_we) um_mem[um_wa] <= um_wd;
    if (fire && pl_we) pl_mem[pl_wa] <= pl_wd;
    if (fire && rx_we) rx_mem[rx_wa] <= rx_wd;
    a_q  <= (fire && um_we && um_wa == a_addr) ? um_wd : um_mem[a_addr];
    b_q  <= (fire && um_we && um_wa == b_addr) ? um_wd : um_mem[b_addr];
    pl_q <= (fire && pl_we && pl_wa == pl_addr) ? pl_wd : pl_mem[pl_addr];
    rx_q <= (fire && rx_we && rx_wa == rx_addr) ? rx_wd : rx_mem[rx_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      uhead_r <= '0; tbase_r <= '0; ucnt_r <= '0; blen_r <= '0;
      tlen_r <= '0; tidx_r <= '0; bldrd_r <= 1'b0; rcmem_r <= 1'b0;
      phead_r <= '0; pcnt_r <= '0; hdr_r <= '0; rcnt_r <= '0;
      rhead_r <= '0; rxcnt_r <= '0; phase_r <= PH_UNSET;
    end else if (fire) begin
      uhead_r <= uhead_nxt; tbase_r <= tbase_nxt; ucnt_r <= ucnt_nxt;
      blen_r <= blen_nxt; tlen_r <= tlen_nxt; tidx_r <= tidx_nxt;
      bldrd_r <= bldrd_nxt; rcmem_r <= rcmem_nxt; phead_r <= phead_nxt;
      pcnt_r <= pcnt_nxt; hdr_r <= hdr_nxt; rcnt_r <= rcnt_nxt;
      rhead_r <= rhead_nxt; rxcnt_r <= rxcnt_nxt; phase_r <= phase_nxt;
    end
  end

endmodule

// ===== rtl/core/i2cms_outq.sv =====
// ----------------------------------------------------------------------------
// i2cms_outq
// Four-word result queue; takes one or two results per input word.
// ----------------------------------------------------------------------------
module i2cms_outq (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  i2cms_pkg::res_pair_t res,
  output logic                 space_ok,
  output logic                 out_valid,
  input  logic                 out_ready,
  output i2cms_pkg::res_t      out_res
);
  import i2cms_pkg::*;

  res_t       q_r [4];
  logic [1:0] wp_r, wp_nxt, rp_r;
  logic [2:0] cnt_r, cnt_nxt;
  logic       pop;

  assign space_ok  = cnt_r <= 3'd2;
  assign out_valid = cnt_r != 3'd0;
  assign out_res   = q_r[rp_r];
  assign pop       = out_valid && out_ready;

  always_comb begin
    wp_nxt  = wp_r;
    cnt_nxt = cnt_r - {2'b00, pop};
    if (push) begin
      wp_nxt  = wp_r + (res.two ? 2'd2 : 2'd1);
      cnt_nxt = cnt_nxt + (res.two ? 3'd2 : 3'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= res.r0;
      if (res.two) q_r[wp_r + 2'd1] <= res.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      cnt_r <= cnt_nxt;
      if (pop) rp_r <= rp_r + 2'd1;
    end
  end

endmodule

// ===== rtl/core/i2c_master_packet_sequencer.sv =====
// A result word is registered in the result queue before it is offered.
// One input word per cycle when not stalled; a stop with restart gives two results.
// Input is taken while the four-word result queue has room for two results.
// Reset (rst_n low, synchronous) empties all queues and sets the bus state unset.
// Byte stores need no clearing; their entries are written before they are read.
// ----------------------------------------------------------------------------
// i2c_master_packet_sequencer
// I2C master packet queueing and bus event sequencing.
// ----------------------------------------------------------------------------
module i2c_master_packet_sequencer (
  input logic        clk,
  input logic        rst_n,
  i2cms_in_if.sink   in_ch,
  i2cms_out_if.source out_ch
);
  import i2cms_pkg::*;

  logic      fire, space_ok;
  res_pair_t res;
  res_t      o_res;

  assign in_ch.ready = space_ok;
  assign fire        = in_ch.valid && space_ok;

  i2cms_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .fire           (fire),
    .cmd            (in_ch.cmd),
    .slave_address  (in_ch.slave_address),
    .read_mode      (in_ch.read_mode),
    .data_byte      (in_ch.data_byte),
    .last_of_packet (in_ch.last_of_packet),
    .bus_status     (in_ch.bus_status),
    .bus_data       (in_ch.bus_data),
    .res            (res)
  );

  i2cms_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (fire),
    .res       (res),
    .space_ok  (space_ok),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_res   (o_res)
  );

  assign out_ch.bus_action      = o_res.act;
  assign out_ch.send_byte       = o_res.send_byte;
  assign out_ch.rx_byte         = o_res.rx_byte;
  assign out_ch.rx_empty        = o_res.rx_empty;
  assign out_ch.bus_error       = o_res.bus_error;
  assign out_ch.bus_state       = o_res.bus_state;
  assign out_ch.pending_packets = o_res.pending;
  assign out_ch.last_result     = o_res.last;

endmodule

// ===== test/i2c_master_packet_sequencer_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// i2c_master_packet_sequencer_tb
// Drives host words (packet queueing, kicks, bus events, pops) into the
// sequencer and checks every result word against a cycle-free model of the
// queues and bus phase held in a small scoreboard.
// ----------------------------------------------------------------------------
module i2c_master_packet_sequencer_tb;
  import i2cms_pkg::*;

  typedef struct {
    cmd_t       cmd;
    logic [6:0] addr;
    logic       rd;
    logic [7:0] db;
    logic       last;
    logic [7:0] st;
    logic [7:0] bd;
  } host_word_t;

  class seq_scoreboard;
    logic [7:0] ubq[UQ_DEPTH];
    int         ubq_head, ubq_cnt;
    int         pkt_len[UQ_DEPTH];
    int         pkt_head, pkt_cnt;
    int         build_len;
    logic [7:0] xfer[TR_DEPTH];
    int         xfer_len, xfer_idx;
    logic [7:0] rxq[RX_DEPTH];
    int         rx_head, rx_cnt;
    phase_t     phase;
    bit         ever_loaded;
    res_t       expected_q[$];
    int         errors;

    function new();
      foreach (ubq[i]) ubq[i] = '0;
      foreach (pkt_len[i]) pkt_len[i] = 0;
      foreach (xfer[i]) xfer[i] = '0;
      foreach (rxq[i]) rxq[i] = '0;
      ubq_head = 0; ubq_cnt = 0; pkt_head = 0; pkt_cnt = 0; build_len = 0;
      xfer_len = 0; xfer_idx = 0; rx_head = 0; rx_cnt = 0;
      phase = PH_UNSET; ever_loaded = 0; errors = 0;
    endfunction

    function void push_result(act_t a, logic [7:0] sb, logic [7:0] rb, logic re,
                              logic err);
      res_t r;
      r.act = a; r.send_byte = sb; r.rx_byte = rb; r.rx_empty = re;
      r.bus_error = err; r.bus_state = phase; r.pending = 7'(pkt_cnt); r.last = 0;
      expected_q.push_back(r);
    endfunction

    function void close_packet();
      if (pkt_cnt < UQ_DEPTH) begin
        pkt_len[(pkt_head + pkt_cnt) % UQ_DEPTH] = build_len;
        pkt_cnt++;
      end
      build_len = 0;
    endfunction

    function bit load_packet();
      int len;
      if (phase == PH_WRITING || phase == PH_READING || pkt_cnt == 0) return 0;
      len = pkt_len[pkt_head];
      pkt_head = (pkt_head + 1) % UQ_DEPTH;
      pkt_cnt--;
      if (len > ubq_cnt) len = ubq_cnt;
      if (len > TR_DEPTH) len = TR_DEPTH;
      for (int i = 0; i < len; i++) xfer[i] = ubq[(ubq_head + i) % UQ_DEPTH];
      ubq_head = (ubq_head + len) % UQ_DEPTH;
      ubq_cnt -= len;
      xfer_len = len;
      xfer_idx = 0;
      phase = xfer[0][0] ? PH_READING : PH_WRITING;
      ever_loaded = 1;
      return 1;
    endfunction

    function int read_count();
      return xfer_len >= 2 ? int'(xfer[1]) : 0;
    endfunction

    function void stop_and_restart(logic err);
      phase = PH_STANDBY;
      xfer_len = 0;
      push_result(ACT_STOP, 0, 0, 0, err);
      if (pkt_cnt > 0 && load_packet()) push_result(ACT_START, 0, 0, 0, err);
    endfunction

    function void push_rx(logic [7:0] b);
      if (rx_cnt < RX_DEPTH) begin
        rxq[(rx_head + rx_cnt) % RX_DEPTH] = b;
        rx_cnt++;
      end
    endfunction

    function void bus_event(logic [7:0] st, logic [7:0] bd);
      int c;
      case (st) inside
        ST_START, ST_RESTART: begin
          xfer_idx = 1;
          push_result(ACT_ACK, xfer[0], 0, 0, 0);
        end
        ST_AW_ACK, ST_DW_ACK: begin
          if (xfer_idx < xfer_len && xfer_idx < TR_DEPTH) begin
            push_result(ACT_ACK, xfer[xfer_idx], 0, 0, 0);
            xfer_idx++;
          end else if (pkt_cnt == 0 || ubq[ubq_head][0] == 1'b0) begin
            stop_and_restart(0);
          end else begin
            // repeated start straight into a queued read
            phase = PH_STANDBY;
            void'(load_packet());
            push_result(ACT_START, 0, 0, 0, 0);
          end
        end
        ST_AR_ACK: push_result(read_count() <= 1 ? ACT_NACK : ACT_ACK, 0, 0, 0, 0);
        ST_DR_ACK: begin
          push_rx(bd);
          c = read_count();
          if (xfer_len >= 2 && c > 0) begin
            c--;
            xfer[1] = 8'(c);
          end
          push_result(c <= 1 ? ACT_NACK : ACT_ACK, 0, 0, 0, 0);
        end
        ST_DR_NACK: begin
          push_rx(bd);
          stop_and_restart(0);
        end
        default: stop_and_restart(1);
      endcase
    endfunction

    function void note_word(host_word_t w);
      case (w.cmd)
        CMD_HEADER: begin
          ubq_cnt -= build_len;
          build_len = 0;
          if (ubq_cnt < UQ_DEPTH) begin
            ubq[(ubq_head + ubq_cnt) % UQ_DEPTH] = {w.addr, w.rd};
            ubq_cnt++;
            build_len = 1;
            if (w.last) close_packet();
          end
          push_result(ACT_NONE, 0, 0, 0, 0);
        end
        CMD_DATA: begin
          if (build_len > 0) begin
            if (ubq_cnt < UQ_DEPTH && build_len < TR_DEPTH) begin
              ubq[(ubq_head + ubq_cnt) % UQ_DEPTH] = w.db;
              ubq_cnt++;
              build_len++;
            end
            if (w.last) close_packet();
          end
          push_result(ACT_NONE, 0, 0, 0, 0);
        end
        CMD_KICK: push_result(load_packet() ? ACT_START : ACT_NONE, 0, 0, 0, 0);
        CMD_EVENT: bus_event(w.st, w.bd);
        CMD_POP: begin
          if (rx_cnt > 0) begin
            push_result(ACT_NONE, 0, rxq[rx_head], 0, 0);
            rx_head = (rx_head + 1) % RX_DEPTH;
            rx_cnt--;
          end else begin
            push_result(ACT_NONE, 0, 8'hFF, 1, 0);
          end
        end
        default: push_result(ACT_NONE, 0, 0, 0, 0);
      endcase
      expected_q[$].last = 1;
    endfunction

    function void field_cmp(string name, int exp_v, int act_v);
      if (exp_v != act_v) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d got %0d", $time, name, exp_v, act_v);
      end
    endfunction

    function void check_result(res_t got);
      res_t e;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result word, expected none got %p", $time, got);
        return;
      end
      e = expected_q.pop_front();
      field_cmp("bus_action", e.act, got.act);
      field_cmp("send_byte", e.send_byte, got.send_byte);
      field_cmp("rx_byte", e.rx_byte, got.rx_byte);
      field_cmp("rx_empty", e.rx_empty, got.rx_empty);
      field_cmp("bus_error", e.bus_error, got.bus_error);
      field_cmp("bus_state", e.bus_state, got.bus_state);
      field_cmp("pending_packets", e.pending, got.pending);
      field_cmp("last_result", e.last, got.last);
    endfunction
  endclass

  localparam int STALL_LIMIT = 5000;

  logic clk;
  logic rst_n;
  i2cms_in_if  in_ch ();
  i2cms_out_if out_ch ();

  i2c_master_packet_sequencer DUT (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  seq_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int quiet_cycles = 0;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(negedge clk) begin
    if (rst_n) out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // monitor and watchdog
  always @(posedge clk) begin
    res_t got;
    host_word_t w;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        w.cmd = cmd_t'(in_ch.cmd); w.addr = in_ch.slave_address; w.rd = in_ch.read_mode;
        w.db = in_ch.data_byte; w.last = in_ch.last_of_packet;
        w.st = in_ch.bus_status; w.bd = in_ch.bus_data;
        sb.note_word(w);
      end
      if (out_ch.valid && out_ch.ready) begin
        got.act = act_t'(out_ch.bus_action); got.send_byte = out_ch.send_byte;
        got.rx_byte = out_ch.rx_byte; got.rx_empty = out_ch.rx_empty;
        got.bus_error = out_ch.bus_error; got.bus_state = phase_t'(out_ch.bus_state);
        got.pending = out_ch.pending_packets; got.last = out_ch.last_result;
        sb.check_result(got);
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("FAIL i2c_master_packet_sequencer");
        $finish;
      end
    end
  end

  task automatic send_word(cmd_t c, logic [6:0] a, logic r, logic [7:0] d, logic l,
                           logic [7:0] s, logic [7:0] b);
    forever begin
      @(negedge clk);
      if ($urandom_range(99) >= send_idle_pct) break;
      in_ch.valid <= 1'b0;
    end
    in_ch.cmd <= c; in_ch.slave_address <= a; in_ch.read_mode <= r;
    in_ch.data_byte <= d; in_ch.last_of_packet <= l;
    in_ch.bus_status <= s; in_ch.bus_data <= b;
    in_ch.valid <= 1'b1;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic send_event(logic [7:0] s);
    send_word(CMD_EVENT, 7'($urandom), 1'($urandom), 8'($urandom), 1'($urandom), s,
              8'($urandom));
  endtask

  // status chosen to follow the bus phase most of the time
  function automatic logic [7:0] pick_status();
    logic [7:0] s;
    int roll;
    roll = $urandom_range(99);
    if (sb.phase == PH_WRITING && roll < 80) s = $urandom_range(1) ? ST_AW_ACK : ST_DW_ACK;
    else if (sb.phase == PH_READING && roll < 85)
      s = roll < 20 ? ST_AR_ACK : (roll < 65 ? ST_DR_ACK : ST_DR_NACK);
    else if (roll < 90 && sb.ever_loaded) s = $urandom_range(1) ? ST_START : ST_RESTART;
    else s = 8'($urandom);
    // start acknowledge sends the header, so keep it away until one was loaded
    if (!sb.ever_loaded && (s == ST_START || s == ST_RESTART)) s = 8'hFF;
    return s;
  endfunction

  task automatic random_word();
    int roll;
    logic [7:0] d;
    roll = $urandom_range(99);
    d = $urandom_range(2) == 0 ? 8'($urandom_range(4)) : 8'($urandom);
    if (roll < 14)
      send_word(CMD_HEADER, 7'($urandom), 1'($urandom), 8'($urandom),
                $urandom_range(9) == 0, 8'($urandom), 8'($urandom));
    else if (roll < 50)
      send_word(CMD_DATA, 7'($urandom), 1'($urandom), d, $urandom_range(3) == 0,
                8'($urandom), 8'($urandom));
    else if (roll < 58)
      send_word(CMD_KICK, 7'($urandom), 1'($urandom), 8'($urandom), 1'($urandom),
                8'($urandom), 8'($urandom));
    else if (roll < 88) send_event(pick_status());
    else if (roll < 98)
      send_word(CMD_POP, 7'($urandom), 1'($urandom), 8'($urandom), 1'($urandom),
                8'($urandom), 8'($urandom));
    else
      send_word(cmd_t'(3'($urandom_range(7, 5))), 7'($urandom), 1'($urandom),
                8'($urandom), 1'($urandom), 8'($urandom), 8'($urandom));
  endtask

  initial begin
    in_ch.valid = 0; in_ch.cmd = CMD_HEADER; in_ch.slave_address = 0; in_ch.read_mode = 0;
    in_ch.data_byte = 0; in_ch.last_of_packet = 0; in_ch.bus_status = 0; in_ch.bus_data = 0;
    out_ch.ready = 0;
    rst_n = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // directed: empty pops, kick with nothing queued, stray codes
    send_word(CMD_POP, 0, 0, 0, 0, 0, 0);
    send_word(CMD_KICK, 0, 0, 0, 0, 0, 0);
    send_word(cmd_t'(3'd7), 7'h7F, 1, 8'hFF, 1, 8'hFF, 8'hFF);
    send_word(CMD_DATA, 0, 0, 8'h55, 1, 0, 0);          // no open packet
    // write packet to address 127 with extreme data, abandoned header first
    send_word(CMD_HEADER, 7'h11, 0, 0, 0, 0, 0);
    send_word(CMD_HEADER, 7'h7F, 0, 0, 0, 0, 0);
    send_word(CMD_DATA, 0, 0, 8'h00, 0, 0, 0);
    send_word(CMD_DATA, 0, 0, 8'hFF, 1, 0, 0);
    // read packet from address 0, count 3, and one read with no count byte
    send_word(CMD_HEADER, 7'h00, 1, 0, 0, 0, 0);
    send_word(CMD_DATA, 0, 0, 8'd3, 1, 0, 0);
    send_word(CMD_HEADER, 7'h2A, 1, 0, 1, 0, 0);
    send_word(CMD_KICK, 0, 0, 0, 0, 0, 0);
    send_word(CMD_KICK, 0, 0, 0, 0, 0, 0);               // busy: ignored
    send_event(ST_START);
    send_event(ST_AW_ACK);
    send_event(ST_DW_ACK);
    send_event(ST_DW_ACK);                               // repeated start into read
    send_event(ST_RESTART);
    send_event(ST_AR_ACK);
    send_word(CMD_EVENT, 0, 0, 0, 0, ST_DR_ACK, 8'hA5);
    send_word(CMD_EVENT, 0, 0, 0, 0, ST_DR_ACK, 8'h00);
    send_word(CMD_EVENT, 0, 0, 0, 0, ST_DR_NACK, 8'hFF); // stop then restart
    send_event(8'h00);                                   // failure code
    send_word(CMD_POP, 0, 0, 0, 0, 0, 0);
    send_event(ST_DW_ACK);                               // stray after stop

    for (int i = 0; i < 560; i++) begin
      case (i / 140)
        0: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
        1: begin send_idle_pct = 62; recv_idle_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_idle_pct = 62; end
        default: begin send_idle_pct = 12; recv_idle_pct = 12; end
      endcase
      random_word();
    end
    @(negedge clk);
    in_ch.valid <= 1'b0;
    recv_idle_pct = 0;

    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.errors == 0) $display("PASS i2c_master_packet_sequencer");
    else $display("FAIL i2c_master_packet_sequencer");
    $finish;
  end
endmodule
